FILE: design/mrfc_pkg.sv
// Shared constants, types and the CRC byte step for the Modbus RTU frame checker.
package mrfc_pkg;

  localparam int FRAME_BUFFER_BYTES = 256;
  localparam int LEN_W              = $clog2(FRAME_BUFFER_BYTES + 1);
  localparam int SHORT_LIMIT        = 3;
  localparam int QUEUE_DEPTH        = 2;
  localparam int QPTR_W             = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W             = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] CRC_START  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
  localparam logic [7:0]  ADDR_RESET = 8'd1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_CRC_ERR    = 3'd1,
    ST_OTHER_ADDR = 3'd2,
    ST_SHORT      = 3'd3,
    ST_OVERFLOW   = 3'd4
  } frame_status_t;

  typedef struct packed {
    frame_status_t          status;
    logic [LEN_W-1:0]       length;
  } frame_rec_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: design/mrfc_front.sv
// Front end: accepts bytes, tracks per-frame CRC and length, classifies finished frames.
module mrfc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  input  logic               accept,
  input  logic [7:0]         rx_byte,
  input  logic               end_of_frame,
  output logic               rec_push,
  output mrfc_pkg::frame_rec_t rec
);
  import mrfc_pkg::*;

  logic [7:0]       slave_addr_r;
  logic [15:0]      crc_r, crc_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;
  logic [7:0]       tail0_r, tail0_nxt;
  logic [7:0]       tail1_r, tail1_nxt;
  logic [7:0]       first_r, first_nxt;
  frame_status_t    status;

  always_comb begin
    first_nxt = (count_r == '0) ? rx_byte : first_r;
    crc_nxt   = (count_r >= LEN_W'(2)) ? crc_byte(crc_r, tail0_r) : crc_r;
    tail0_nxt = tail1_r;
    tail1_nxt = rx_byte;
    count_nxt = (count_r < LEN_W'(FRAME_BUFFER_BYTES)) ? count_r + LEN_W'(1) : count_r;
  end

  always_comb begin
    priority if (count_nxt <= LEN_W'(SHORT_LIMIT)) begin
      status = ST_SHORT;
    end else if (count_nxt >= LEN_W'(FRAME_BUFFER_BYTES)) begin
      status = ST_OVERFLOW;
    end else if (first_nxt != slave_addr_r) begin
      status = ST_OTHER_ADDR;
    end else if ({tail1_nxt, tail0_nxt} == crc_nxt) begin
      status = ST_OK;
    end else begin
      status = ST_CRC_ERR;
    end
  end

  assign rec_push   = accept && end_of_frame;
  assign rec.status = status;
  assign rec.length = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= ADDR_RESET;
    end else if (cfg_we) begin
      slave_addr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_START;
      count_r <= '0;
      tail0_r <= '0;
      tail1_r <= '0;
      first_r <= '0;
    end else if (accept) begin
      if (end_of_frame) begin
        crc_r   <= CRC_START;
        count_r <= '0;
        tail0_r <= '0;
        tail1_r <= '0;
        first_r <= '0;
      end else begin
        crc_r   <= crc_nxt;
        count_r <= count_nxt;
        tail0_r <= tail0_nxt;
        tail1_r <= tail1_nxt;
        first_r <= first_nxt;
      end
    end
  end

endmodule

FILE: design/mrfc_queue.sv
// Short queue of frame records between the front end and the back end.
module mrfc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mrfc_pkg::frame_rec_t push_rec,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output mrfc_pkg::frame_rec_t pop_rec
);
  import mrfc_pkg::*;

  frame_rec_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_rec = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

FILE: design/mrfc_back.sv
// Back end: updates the saturating error counters and holds the result register.
module mrfc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  mrfc_pkg::frame_rec_t q_rec,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [2:0]           out_frame_status,
  output logic [8:0]           out_frame_length,
  output logic [15:0]          out_crc_error_count,
  output logic [15:0]          out_short_frame_count
);
  import mrfc_pkg::*;

  logic             valid_r;
  logic [15:0]      crc_cnt_r, crc_cnt_nxt;
  logic [15:0]      short_cnt_r, short_cnt_nxt;
  frame_status_t    status_r;
  logic [LEN_W-1:0] length_r;

  assign q_pop = !q_empty && (!valid_r || out_pop);

  always_comb begin
    crc_cnt_nxt   = crc_cnt_r;
    short_cnt_nxt = short_cnt_r;
    if (q_rec.status == ST_CRC_ERR && crc_cnt_r != COUNT_MAX) begin
      crc_cnt_nxt = crc_cnt_r + 16'd1;
    end
    if (q_rec.status == ST_SHORT && short_cnt_r != COUNT_MAX) begin
      short_cnt_nxt = short_cnt_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      crc_cnt_r   <= '0;
      short_cnt_r <= '0;
    end else begin
      if (q_pop) begin
        valid_r     <= 1'b1;
        crc_cnt_r   <= crc_cnt_nxt;
        short_cnt_r <= short_cnt_nxt;
      end else if (out_pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r <= q_rec.status;
      length_r <= q_rec.length;
    end
  end

  assign out_empty             = !valid_r;
  assign out_frame_status      = status_r;
  assign out_frame_length      = 9'(length_r);
  assign out_crc_error_count   = crc_cnt_r;
  assign out_short_frame_count = short_cnt_r;

endmodule

FILE: design/modbus_rtu_frame_checker_unit.sv
// Top level of the Modbus RTU receive frame checker.
// Received bytes enter one per transaction, at up to one per clock cycle; a byte marked
// as the end of a frame yields one status transaction that classifies the frame (good
// unicast, CRC error, other address, too short, overflow) with its length and the two
// saturating error counters. The CRC update of one byte is a combinational step in the
// front end; a status reaches the result ports after passing a two-entry frame queue
// and the back-end counter stage. The input reports full only when that queue is full
// because results are not being popped.
module modbus_rtu_frame_checker_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_end_of_frame,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_frame_status,
  output logic [8:0]  out_frame_length,
  output logic [15:0] out_crc_error_count,
  output logic [15:0] out_short_frame_count
);
  import mrfc_pkg::*;

  logic       accept;
  logic       rec_push;
  frame_rec_t rec_in, rec_out;
  logic       q_empty, q_pop;

  assign accept = in_push && !in_full;

  mrfc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .rx_byte      (in_rx_byte),
    .end_of_frame (in_end_of_frame),
    .rec_push     (rec_push),
    .rec          (rec_in)
  );

  mrfc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_push),
    .push_rec (rec_in),
    .full     (in_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_rec  (rec_out)
  );

  mrfc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_empty               (q_empty),
    .q_rec                 (rec_out),
    .q_pop                 (q_pop),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_frame_status      (out_frame_status),
    .out_frame_length      (out_frame_length),
    .out_crc_error_count   (out_crc_error_count),
    .out_short_frame_count (out_short_frame_count)
  );

endmodule

FILE: tb/sv/mrfc_tb_pkg.sv
`timescale 1ns / 100ps
// Frame checker scoreboard and the CRC-16 step used to build and predict Modbus RTU frames.
package mrfc_tb_pkg;
  import mrfc_pkg::*;

  function automatic logic [15:0] modbus_crc_update(input logic [15:0] crc,
                                                    input logic [7:0] data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    repeat (8) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

  typedef struct {
    frame_status_t    status;
    logic [LEN_W-1:0] length;
    logic [15:0]      crc_errors;
    logic [15:0]      short_frames;
  } frame_outcome_t;

  class frame_scoreboard;
    logic [7:0]     station_addr;
    logic [15:0]    crc_acc;
    int unsigned    byte_cnt;
    logic [7:0]     tail [2];
    logic [7:0]     lead_byte;
    logic [15:0]    crc_fail_cnt;
    logic [15:0]    short_cnt;
    frame_outcome_t outcomes [$];
    int unsigned    mismatches;

    function new();
      station_addr = ADDR_RESET;
      crc_fail_cnt = '0;
      short_cnt = '0;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      crc_acc = CRC_START;
      byte_cnt = 0;
      tail[0] = '0;
      tail[1] = '0;
      lead_byte = '0;
    endfunction

    function int unsigned pending();
      return outcomes.size();
    endfunction

    function void note_byte(input logic [7:0] data, input logic last);
      frame_outcome_t res;
      if (byte_cnt == 0) begin
        lead_byte = data;
      end
      if (byte_cnt >= 2) begin
        crc_acc = modbus_crc_update(crc_acc, tail[0]);
      end
      tail[0] = tail[1];
      tail[1] = data;
      if (byte_cnt < FRAME_BUFFER_BYTES) begin
        byte_cnt++;
      end
      if (!last) begin
        return;
      end
      if (byte_cnt <= SHORT_LIMIT) begin
        res.status = ST_SHORT;
        if (short_cnt != COUNT_MAX) begin
          short_cnt++;
        end
      end else if (byte_cnt >= FRAME_BUFFER_BYTES) begin
        res.status = ST_OVERFLOW;
      end else if (lead_byte != station_addr) begin
        res.status = ST_OTHER_ADDR;
      end else if ({tail[1], tail[0]} == crc_acc) begin
        res.status = ST_OK;
      end else begin
        res.status = ST_CRC_ERR;
        if (crc_fail_cnt != COUNT_MAX) begin
          crc_fail_cnt++;
        end
      end
      res.length = LEN_W'(byte_cnt);
      res.crc_errors = crc_fail_cnt;
      res.short_frames = short_cnt;
      outcomes.push_back(res);
      clear_frame();
    endfunction

    task report_mismatch(input string what);
      if (mismatches < 40) begin
        $display("MISMATCH at %0t: %s", $time, what);
      end
      mismatches++;
    endtask

    task check_outcome(input logic [2:0] status, input logic [LEN_W-1:0] length,
                       input logic [15:0] crc_errors, input logic [15:0] short_frames);
      frame_outcome_t want;
      if (outcomes.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction, status %0d length %0d",
                                  status, length));
        return;
      end
      want = outcomes.pop_front();
      if (status !== want.status) begin
        report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      end
      if (length !== want.length) begin
        report_mismatch($sformatf("length %0d, expected %0d", length, want.length));
      end
      if (crc_errors !== want.crc_errors) begin
        report_mismatch($sformatf("crc error count %0d, expected %0d",
                                  crc_errors, want.crc_errors));
      end
      if (short_frames !== want.short_frames) begin
        report_mismatch($sformatf("short frame count %0d, expected %0d",
                                  short_frames, want.short_frames));
      end
    endtask
  endclass

endpackage

FILE: tb/sv/modbus_rtu_frame_checker_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the Modbus RTU frame checker: directed, random and length-boundary traffic.
module modbus_rtu_frame_checker_unit_tb;
  import mrfc_pkg::*;
  import mrfc_tb_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_data = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_rx_byte = '0;
  logic        in_end_of_frame = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [2:0]  out_frame_status;
  logic [8:0]  out_frame_length;
  logic [15:0] out_crc_error_count;
  logic [15:0] out_short_frame_count;

  frame_scoreboard sb;
  int unsigned     send_idle_pct = 0;
  int unsigned     pop_stall_pct = 0;
  int unsigned     items_sent = 0;
  logic [7:0]      station_addr = ADDR_RESET;
  logic [7:0]      frame_buf [$];

  modbus_rtu_frame_checker_unit u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_data              (cfg_data),
    .in_push               (in_push),
    .in_full               (in_full),
    .in_rx_byte            (in_rx_byte),
    .in_end_of_frame       (in_end_of_frame),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_frame_status      (out_frame_status),
    .out_frame_length      (out_frame_length),
    .out_crc_error_count   (out_crc_error_count),
    .out_short_frame_count (out_short_frame_count)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      sb.check_outcome(out_frame_status, out_frame_length, out_crc_error_count,
                       out_short_frame_count);
    end
    out_pop <= (pop_stall_pct == 0) || ($urandom_range(99) >= pop_stall_pct);
  end

  task automatic push_byte(input logic [7:0] data, input logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      in_rx_byte <= 8'($urandom);
      in_end_of_frame <= 1'($urandom);
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_rx_byte <= data;
    in_end_of_frame <= last;
    @(posedge clk);
    while (in_full) begin
      @(posedge clk);
    end
    sb.note_byte(data, last);
    items_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) begin
      push_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  task automatic load_frame(input logic [7:0] addr, input int body_len, input bit good_crc);
    logic [15:0] crc;
    frame_buf = '{addr};
    repeat (body_len) begin
      frame_buf.push_back(8'($urandom));
    end
    crc = CRC_START;
    foreach (frame_buf[i]) begin
      crc = modbus_crc_update(crc, frame_buf[i]);
    end
    if (!good_crc) begin
      crc ^= 16'($urandom_range(1, 65535));
    end
    frame_buf.push_back(crc[7:0]);
    frame_buf.push_back(crc[15:8]);
  endtask

  task automatic send_random_frame();
    int unsigned pick;
    logic [7:0]  other;
    pick = $urandom_range(99);
    other = 8'($urandom);
    if (other == station_addr) begin
      other = ~station_addr;
    end
    if (pick < 70) begin
      load_frame(station_addr, $urandom_range(1, 20), $urandom_range(99) >= 15);
    end else if (pick < 80) begin
      load_frame(($urandom_range(3) == 0) ? 8'h00 : other, $urandom_range(1, 20),
                 $urandom_range(1));
    end else if (pick < 88) begin
      frame_buf.delete();
      repeat ($urandom_range(1, 3)) begin
        frame_buf.push_back(8'($urandom));
      end
    end else if (pick < 89) begin
      load_frame(station_addr, $urandom_range(249, 259), $urandom_range(1));
    end else begin
      frame_buf.delete();
      repeat ($urandom_range(1, 30)) begin
        frame_buf.push_back(8'($urandom));
      end
    end
    send_frame();
  endtask

  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_address(input logic [7:0] addr);
    cfg_we <= 1'b1;
    cfg_data <= addr;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.station_addr = addr;
    station_addr = addr;
    @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    send_idle_pct = (mode == 1) ? 51 : (mode == 3) ? 17 : 0;
    pop_stall_pct = (mode == 2) ? 51 : (mode == 3) ? 17 : 0;
  endtask

  initial begin
    #8_000_000;
    $display("modbus_rtu_frame_checker_unit test failed");
    $finish;
  end

  initial begin
    logic [7:0] addr;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    frame_buf = '{8'hFF};
    send_frame();
    frame_buf = '{8'h00, 8'h00};
    send_frame();
    frame_buf = '{8'h01, 8'h55, 8'hAA};
    send_frame();
    load_frame(station_addr, 1, 1'b1);
    send_frame();
    load_frame(station_addr, 1, 1'b0);
    send_frame();
    load_frame(8'h11, 1, 1'b1);
    send_frame();
    load_frame(8'h00, 1, 1'b1);
    send_frame();

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        1:       addr = 8'h00;
        2:       addr = 8'hFF;
        4:       addr = 8'h01;
        6:       addr = 8'hFE;
        default: addr = 8'($urandom);
      endcase
      if (p != 0) begin
        write_address(addr);
      end
      set_idling(p % 4);
      items_sent = 0;
      while (items_sent < 95) begin
        send_random_frame();
      end
    end

    settle();
    set_idling(0);
    load_frame(station_addr, 252, 1'b1);
    send_frame();
    load_frame(station_addr, 253, 1'b1);
    send_frame();
    load_frame(station_addr, 254, 1'b1);
    send_frame();
    load_frame(station_addr, 297, 1'b0);
    send_frame();

    settle();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("modbus_rtu_frame_checker_unit test passed");
    end else begin
      $display("modbus_rtu_frame_checker_unit test failed");
    end
    $finish;
  end

endmodule
